### rtl/core/srlm_pkg.sv
// Shared types and constants for the stereo RMS level meter.
package srlm_pkg;

	localparam int SAMPLE_W   = 16;
	localparam int SUM_W      = 40;
	localparam int LEVEL_W    = 16;
	localparam int TENTHS_W   = 11;
	localparam int OP_W       = 19;
	localparam int PROD_W     = 2 * OP_W;
	localparam int ROOT_W     = SUM_W / 2;
	localparam int REM_W      = ROOT_W + 4;
	localparam int SQRT_STEPS = ROOT_W;
	localparam int ITER_W     = $clog2(SQRT_STEPS);

	localparam int DEF_PAIRS_PER_BLOCK = 256;

	// 0.93 and 0.07 over 65536
	localparam logic [OP_W-1:0] COEF_KEEP  = OP_W'(60948);
	localparam logic [OP_W-1:0] COEF_NEW   = OP_W'(4588);
	// level * 195000 / (17 * 65536): multiply, drop 16 bits, then divide by 17
	// through ceil(2^22 / 17), exact for dividends below 2^20
	localparam logic [OP_W-1:0] MAP_NUM    = OP_W'(195000);
	localparam logic [OP_W-1:0] RECIP_17   = OP_W'(246724);
	localparam int              MAP_HI     = 16;
	localparam int              RECIP_SH   = 22;
	localparam int              MAP_Q_W    = 14;
	localparam logic [TENTHS_W-1:0] TENTHS_LOW  = TENTHS_W'(50);
	localparam logic [TENTHS_W-1:0] TENTHS_HIGH = TENTHS_W'(2000);
	localparam logic [MAP_Q_W-1:0]  MAP_Q_MAX   = MAP_Q_W'(1950);

	typedef enum logic [2:0] {
		MUL_LEFT,
		MUL_RIGHT,
		MUL_KEEP,
		MUL_NEW,
		MUL_MAP,
		MUL_RECIP
	} mul_sel_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SQ_L,
		ST_SQ_R,
		ST_ACC,
		ST_SHIFT,
		ST_SQRT,
		ST_MIX1,
		ST_MIX2,
		ST_MIX3,
		ST_MAP1,
		ST_MAP2,
		ST_MAP3
	} state_t;

	typedef struct packed {
		logic     load_in;
		logic     mul_en;
		mul_sel_t mul_sel;
		logic     acc_add;
		logic     count_inc;
		logic     block_start;
		logic     sqrt_step;
		logic     mix_hold;
		logic     smooth_load;
		logic     out_load;
	} cmd_t;

	typedef struct packed {
		logic close;
		logic out_free;
	} status_t;

endpackage

### rtl/core/srlm_ctrl.sv
// Sequencer for the level meter: accumulation steps and the block-close sequence.
module srlm_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  srlm_pkg::status_t status,
	output srlm_pkg::cmd_t    cmd
);
	import srlm_pkg::*;

	state_t              state_q;
	state_t              state_d;
	logic [ITER_W-1:0]   iter_q;
	logic [ITER_W-1:0]   iter_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			iter_q  <= '0;
		end else begin
			state_q <= state_d;
			iter_q  <= iter_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		iter_d   = iter_q;
		cmd      = '0;
		cmd.mul_sel = MUL_LEFT;
		in_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d     = ST_SQ_L;
				end
			end
			ST_SQ_L: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_LEFT;
				state_d     = ST_SQ_R;
			end
			ST_SQ_R: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_RIGHT;
				cmd.acc_add = 1'b1;
				state_d     = ST_ACC;
			end
			ST_ACC: begin
				cmd.acc_add = 1'b1;
				if (status.close) begin
					state_d = ST_SHIFT;
				end else begin
					cmd.count_inc = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			ST_SHIFT: begin
				cmd.block_start = 1'b1;
				iter_d          = '0;
				state_d         = ST_SQRT;
			end
			ST_SQRT: begin
				cmd.sqrt_step = 1'b1;
				iter_d        = iter_q + 1'b1;
				if (iter_q == ITER_W'(SQRT_STEPS - 1)) begin
					state_d = ST_MIX1;
				end
			end
			ST_MIX1: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_KEEP;
				state_d     = ST_MIX2;
			end
			ST_MIX2: begin
				cmd.mul_en   = 1'b1;
				cmd.mul_sel  = MUL_NEW;
				cmd.mix_hold = 1'b1;
				state_d      = ST_MIX3;
			end
			ST_MIX3: begin
				cmd.smooth_load = 1'b1;
				state_d         = ST_MAP1;
			end
			ST_MAP1: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_MAP;
				state_d     = ST_MAP2;
			end
			ST_MAP2: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_RECIP;
				state_d     = ST_MAP3;
			end
			ST_MAP3: begin
				if (status.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

### rtl/core/srlm_dp.sv
// Datapath of the level meter: shared multiplier, sum, root, smoother, output register.
module srlm_dp #(
	parameter int PAIRS_PER_BLOCK = srlm_pkg::DEF_PAIRS_PER_BLOCK
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic signed [srlm_pkg::SAMPLE_W-1:0]   left_sample,
	input  logic signed [srlm_pkg::SAMPLE_W-1:0]   right_sample,
	input  logic                                   block_end,
	output logic [srlm_pkg::LEVEL_W-1:0]           smoothed_level,
	output logic [srlm_pkg::TENTHS_W-1:0]          scaled_level_tenths,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	input  srlm_pkg::cmd_t                         cmd,
	output srlm_pkg::status_t                      status
);
	import srlm_pkg::*;

	localparam int CNT_W = (PAIRS_PER_BLOCK > 1) ? $clog2(PAIRS_PER_BLOCK) : 1;
	localparam int N_W   = $clog2(PAIRS_PER_BLOCK + 1);
	localparam int SH_W  = $clog2(N_W + 1);

	logic signed [SAMPLE_W-1:0] left_q;
	logic signed [SAMPLE_W-1:0] right_q;
	logic                       block_end_q;
	logic signed [OP_W-1:0]     op_a;
	logic signed [OP_W-1:0]     op_b;
	logic signed [PROD_W-1:0]   prod;
	logic signed [PROD_W-1:0]   p_q;
	logic [SUM_W-1:0]           acc_q;
	logic [SUM_W:0]             acc_sum;
	logic [CNT_W-1:0]           count_q;
	logic [N_W-1:0]             n_pairs;
	logic [SH_W-1:0]            shift;
	logic [SUM_W-1:0]           rad_q;
	logic [REM_W-1:0]           rem_q;
	logic [REM_W-1:0]           rem_sh;
	logic [REM_W-1:0]           trial;
	logic [ROOT_W-1:0]          root_q;
	logic [LEVEL_W-1:0]         rms;
	logic [31:0]                mix_q;
	logic [31:0]                mix_sum;
	logic [LEVEL_W-1:0]         sm_q;
	logic [MAP_Q_W-1:0]         map_q;
	logic [TENTHS_W-1:0]        tenths;
	logic                       out_valid_q;
	logic [LEVEL_W-1:0]         out_level_q;
	logic [TENTHS_W-1:0]        out_tenths_q;

	// pairs in the open block, this one included
	assign n_pairs = N_W'(count_q) + N_W'(1);
	assign status.close = block_end_q || (n_pairs == N_W'(PAIRS_PER_BLOCK));
	assign status.out_free = !out_valid_q || !out_stall;

	// shift = floor(log2(n)) + 1
	always_comb begin
		shift = '0;
		for (int i = 0; i < N_W; i++) begin
			if (n_pairs[i]) begin
				shift = SH_W'(i + 1);
			end
		end
	end

	assign rms = (root_q[ROOT_W-1:LEVEL_W] != '0) ? '1 : root_q[LEVEL_W-1:0];

	always_comb begin
		op_a = '0;
		op_b = '0;
		unique case (cmd.mul_sel)
			MUL_LEFT: begin
				op_a = OP_W'(left_q);
				op_b = OP_W'(left_q);
			end
			MUL_RIGHT: begin
				op_a = OP_W'(right_q);
				op_b = OP_W'(right_q);
			end
			MUL_KEEP: begin
				op_a = signed'({3'b0, sm_q});
				op_b = signed'(COEF_KEEP);
			end
			MUL_NEW: begin
				op_a = signed'({3'b0, rms});
				op_b = signed'(COEF_NEW);
			end
			MUL_MAP: begin
				op_a = signed'({3'b0, sm_q});
				op_b = signed'(MAP_NUM);
			end
			MUL_RECIP: begin
				op_a = signed'({1'b0, p_q[MAP_HI+OP_W-2:MAP_HI]});
				op_b = signed'(RECIP_17);
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	assign prod    = op_a * op_b;
	assign acc_sum = {1'b0, acc_q} + {3'b0, p_q};
	assign mix_sum = mix_q + p_q[31:0];

	assign rem_sh = {rem_q[REM_W-3:0], rad_q[SUM_W-1:SUM_W-2]};
	assign trial  = {{(REM_W-ROOT_W-2){1'b0}}, root_q, 2'b01};

	assign map_q  = p_q[RECIP_SH+MAP_Q_W-1:RECIP_SH];
	assign tenths = (map_q > MAP_Q_MAX) ? TENTHS_HIGH : TENTHS_LOW + TENTHS_W'(map_q);

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			left_q  <= left_sample;
			right_q <= right_sample;
		end
		if (cmd.mul_en) begin
			p_q <= prod;
		end
		if (cmd.mix_hold) begin
			mix_q <= p_q[31:0];
		end
		if (cmd.block_start) begin
			rad_q  <= acc_q >> shift;
			rem_q  <= '0;
			root_q <= '0;
		end else if (cmd.sqrt_step) begin
			rad_q <= {rad_q[SUM_W-3:0], 2'b00};
			if (rem_sh >= trial) begin
				rem_q  <= rem_sh - trial;
				root_q <= {root_q[ROOT_W-2:0], 1'b1};
			end else begin
				rem_q  <= rem_sh;
				root_q <= {root_q[ROOT_W-2:0], 1'b0};
			end
		end
		if (cmd.out_load) begin
			out_level_q  <= sm_q;
			out_tenths_q <= tenths;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_end_q <= 1'b0;
			acc_q       <= '0;
			count_q     <= '0;
			sm_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load_in) begin
				block_end_q <= block_end;
			end
			if (cmd.block_start) begin
				acc_q   <= '0;
				count_q <= '0;
			end else begin
				if (cmd.acc_add) begin
					// saturate at all ones
					acc_q <= acc_sum[SUM_W] ? '1 : acc_sum[SUM_W-1:0];
				end
				if (cmd.count_inc) begin
					count_q <= n_pairs[CNT_W-1:0];
				end
			end
			if (cmd.smooth_load) begin
				sm_q <= mix_sum[31:16];
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid           = out_valid_q;
	assign smoothed_level      = out_level_q;
	assign scaled_level_tenths = out_tenths_q;

endmodule

### rtl/core/stereo_rms_level_meter.sv
// Top level of the stereo RMS level meter: sequencer plus datapath.
//
//   channel  direction  handshake            fields
//   in       in         in_valid / in_stall  left_sample, right_sample, block_end
//   out      out        out_valid/out_stall  smoothed_level, scaled_level_tenths
//
// An item that does not close a block goes through capture, square left,
// square right and final add; one multiplier is shared by both squares.
// An item that closes a block goes through the same steps, a mean shift,
// 20 root iterations (two radicand bits per cycle), then smoother and level
// map on the same multiplier, plus any wait for the output register.
// Reset clears the running sum, pair count, smoothed level and output valid.
// A finished result waits in the output register while out_stall is high;
// the next item is accepted meanwhile, and a later result holds only if the
// register is still full when it is ready.
module stereo_rms_level_meter #(
	parameter int PAIRS_PER_BLOCK = srlm_pkg::DEF_PAIRS_PER_BLOCK
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic signed [srlm_pkg::SAMPLE_W-1:0] left_sample,
	input  logic signed [srlm_pkg::SAMPLE_W-1:0] right_sample,
	input  logic                                 block_end,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [srlm_pkg::LEVEL_W-1:0]         smoothed_level,
	output logic [srlm_pkg::TENTHS_W-1:0]        scaled_level_tenths
);
	import srlm_pkg::*;

	cmd_t    cmd;
	status_t status;

	// step through accumulation and the block-close sequence
	srlm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	// hold the sum, root, smoother and output register
	srlm_dp #(
		.PAIRS_PER_BLOCK (PAIRS_PER_BLOCK)
	) u_dp (
		.clk                 (clk),
		.arst_n              (arst_n),
		.left_sample         (left_sample),
		.right_sample        (right_sample),
		.block_end           (block_end),
		.smoothed_level      (smoothed_level),
		.scaled_level_tenths (scaled_level_tenths),
		.out_valid           (out_valid),
		.out_stall           (out_stall),
		.cmd                 (cmd),
		.status              (status)
	);

endmodule

### dv/testbench.sv
// Self-checking testbench for the stereo RMS level meter: random stimulus, scoreboard.
module testbench;
	import srlm_pkg::*;

	localparam int BLOCK_PAIRS = 256;
	localparam int TOTAL_PAIRS = 750;
	localparam int TAIL_PAIRS  = 100;   // final stretch driven with no idling at all
	localparam int HANG_LIMIT  = 2000;  // cycles with nothing accepted before giving up
	localparam int DRAIN_WAIT  = 40;    // longer than one block-closing item
	localparam int MAX_REPORTS = 10;

	// Smoother weights (Q0.16 fixed point) and level-map constants.
	localparam longint unsigned KEEP_WEIGHT = 60948;
	localparam longint unsigned NEW_WEIGHT  = 4588;
	localparam longint unsigned SPAN_NUM    = 195000;
	localparam longint unsigned SPAN_DEN    = 1114112;
	localparam longint unsigned FLOOR_TENTH = 50;
	localparam longint unsigned CEIL_TENTH  = 2000;
	localparam longint unsigned ENERGY_CEIL = (64'd1 << SUM_W) - 64'd1;

	typedef struct packed {
		logic [LEVEL_W-1:0]  level;
		logic [TENTHS_W-1:0] tenths;
	} level_rec_t;

	// Track the block energy and smoothed level, queue one record per closed block,
	// and check each delivered result against the oldest queued one.
	class level_tracker;
		logic [SUM_W-1:0]   energy;
		int                 pairs_open;
		logic [LEVEL_W-1:0] level_now;
		level_rec_t         pending_levels[$];
		int                 errors;
		int                 mismatches;
		int                 blocks_closed;
		int                 forced_closes;
		int                 pairs_seen;

		function new();
			energy        = '0;
			pairs_open    = 0;
			level_now     = '0;
			errors        = 0;
			mismatches    = 0;
			blocks_closed = 0;
			forced_closes = 0;
			pairs_seen    = 0;
		endfunction

		function logic [SUM_W-1:0] add_energy(logic [SUM_W-1:0] acc,
			logic signed [SAMPLE_W-1:0] s);
			longint          sv;
			longint unsigned total;
			sv    = longint'(s);
			total = longint'(acc) + longint'(sv * sv);
			if (total > ENERGY_CEIL)
				total = ENERGY_CEIL;
			return total[SUM_W-1:0];
		endfunction

		// Digit-by-digit integer square root, floor.
		function logic [31:0] floor_root(logic [63:0] v);
			logic [63:0] root;
			logic [63:0] probe;
			root  = '0;
			probe = 64'h4000_0000_0000_0000;
			while (probe > v)
				probe = probe >> 2;
			while (probe != 0) begin
				if (v >= root + probe) begin
					v    = v - (root + probe);
					root = (root >> 1) + probe;
				end else begin
					root = root >> 1;
				end
				probe = probe >> 2;
			end
			return root[31:0];
		endfunction

		function void take_pair(logic signed [SAMPLE_W-1:0] l,
			logic signed [SAMPLE_W-1:0] r, logic last);
			int              n;
			int              shift;
			logic [31:0]     rms;
			longint unsigned mix;
			longint unsigned tenths;
			level_rec_t      rec;
			pairs_seen++;
			energy = add_energy(energy, l);
			energy = add_energy(energy, r);
			n = (pairs_open + 1) & 12'hFFF;
			if (!last && n < BLOCK_PAIRS) begin
				pairs_open = n;
				return;
			end
			// Divide by the largest power of two not above 2n.
			shift = 1;
			while ((n >> shift) != 0)
				shift++;
			rms = floor_root(64'(energy) >> shift);
			if (rms > 32'd65535)
				rms = 32'd65535;
			mix       = KEEP_WEIGHT * longint'(level_now) + NEW_WEIGHT * longint'(rms);
			level_now = mix[LEVEL_W+15:16];
			tenths    = FLOOR_TENTH + (longint'(level_now) * SPAN_NUM) / SPAN_DEN;
			if (tenths > CEIL_TENTH)
				tenths = CEIL_TENTH;
			rec.level  = level_now;
			rec.tenths = tenths[TENTHS_W-1:0];
			pending_levels.insert(pending_levels.size(), rec);
			blocks_closed++;
			if (!last)
				forced_closes++;
			energy     = '0;
			pairs_open = 0;
		endfunction

		function void check_level(logic [LEVEL_W-1:0] level, logic [TENTHS_W-1:0] tenths);
			level_rec_t want;
			if (pending_levels.size() == 0) begin
				errors++;
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("unexpected result: level %0d tenths %0d", level, tenths);
				return;
			end
			want = pending_levels.pop_front();
			if (level !== want.level || tenths !== want.tenths) begin
				errors++;
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("mismatch: level %0d (want %0d) tenths %0d (want %0d)",
						level, want.level, tenths, want.tenths);
			end
		endfunction
	endclass

	logic                       clk = 1'b0;
	logic                       arst_n;
	logic                       in_valid;
	logic                       in_stall;
	logic signed [SAMPLE_W-1:0] left_sample;
	logic signed [SAMPLE_W-1:0] right_sample;
	logic                       block_end;
	logic                       out_valid;
	logic                       out_stall = 1'b0;
	logic [LEVEL_W-1:0]         smoothed_level;
	logic [TENTHS_W-1:0]        scaled_level_tenths;

	level_tracker tracker = new();
	bit           quiet_tail = 1'b0;
	int           pairs_sent = 0;
	int           idle_cycles = 0;
	int           out_hold = 0;

	stereo_rms_level_meter #(
		.PAIRS_PER_BLOCK(BLOCK_PAIRS)
	) uut (
		.clk                (clk),
		.arst_n             (arst_n),
		.in_valid           (in_valid),
		.in_stall           (in_stall),
		.left_sample        (left_sample),
		.right_sample       (right_sample),
		.block_end          (block_end),
		.out_valid          (out_valid),
		.out_stall          (out_stall),
		.smoothed_level     (smoothed_level),
		.scaled_level_tenths(scaled_level_tenths)
	);

	always #6 clk = ~clk;

	// Monitor: sample both handshakes on the rising edge, before the block updates.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				tracker.take_pair(left_sample, right_sample, block_end);
			if (out_valid && !out_stall)
				tracker.check_level(smoothed_level, scaled_level_tenths);
		end
	end

	// Watchdog: count cycles where neither channel moves an item.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= HANG_LIMIT) begin
				$display("timeout: nothing accepted for %0d cycles", HANG_LIMIT);
				$display("testbench: done, errors");
				$finish;
			end
		end
	end

	// Receiver back-pressure: random stall bursts, none in the tail.
	always @(negedge clk) begin
		if (quiet_tail) begin
			out_stall <= 1'b0;
			out_hold  <= 0;
		end else if (out_hold > 0) begin
			out_stall <= 1'b1;
			out_hold  <= out_hold - 1;
		end else if ($urandom_range(0, 5) == 0) begin
			out_stall <= 1'b1;
			out_hold  <= $urandom_range(0, 7);
		end else begin
			out_stall <= 1'b0;
		end
	end

	// Offer one item; call at a falling edge, return at the falling edge after acceptance.
	task automatic push_pair(logic signed [SAMPLE_W-1:0] l, logic signed [SAMPLE_W-1:0] r,
		logic last);
		int gap;
		quiet_tail = (pairs_sent >= TOTAL_PAIRS - TAIL_PAIRS);
		if (!quiet_tail && $urandom_range(0, 3) == 0) begin
			// Drop valid for a burst before the item.
			gap = $urandom_range(1, 8);
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid     <= 1'b1;
		left_sample  <= l;
		right_sample <= r;
		block_end    <= last;
		// Hold the payload until an edge sees stall low.
		do
			@(posedge clk);
		while (in_stall);
		pairs_sent++;
		@(negedge clk);
	endtask

	// Draw a sample scaled down by amp bits, with the rails now and then.
	function automatic logic signed [SAMPLE_W-1:0] draw_sample(int amp);
		int unsigned                roll;
		logic signed [SAMPLE_W-1:0] raw;
		roll = $urandom_range(0, 19);
		if (roll == 0)
			return 16'sh8000;
		if (roll == 1)
			return 16'sh7FFF;
		raw = SAMPLE_W'($urandom_range(0, 65535));
		return raw >>> amp;
	endfunction

	initial begin
		int run_no;
		int len;
		int amp;
		int pick;
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		left_sample  = '0;
		right_sample = '0;
		block_end    = 1'b0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: single-pair blocks at both rails and at zero.
		push_pair(16'sh8000, 16'sh8000, 1'b1);
		push_pair(16'sh7FFF, 16'sh7FFF, 1'b1);
		push_pair(16'sh0000, 16'sh0000, 1'b1);
		// Two pairs, opposite rails.
		push_pair(16'sh8000, 16'sh7FFF, 1'b0);
		push_pair(16'sh7FFF, 16'sh8000, 1'b1);
		// Three pairs: count not a power of two, alternating bit patterns.
		push_pair(16'sh5555, -16'sh5556, 1'b0);
		push_pair(-16'sh5556, 16'sh5555, 1'b0);
		push_pair(16'sh5555, 16'sh5555, 1'b1);
		// Four tiny pairs: root rounds down to zero.
		push_pair(16'sh0001, -16'sh0001, 1'b0);
		push_pair(-16'sh0001, 16'sh0001, 1'b0);
		push_pair(16'sh0001, 16'sh0000, 1'b0);
		push_pair(16'sh0000, -16'sh0001, 1'b1);
		// Full-scale blocks in a row: push the level map into its upper clamp.
		repeat (8)
			push_pair(16'sh8000, 16'sh7FFF, 1'b1);

		// Random blocks of random loudness; one block runs past the length limit.
		run_no = 0;
		while (pairs_sent < TOTAL_PAIRS) begin
			pick = $urandom_range(0, 19);
			if (run_no == 2)
				len = BLOCK_PAIRS + $urandom_range(1, 20);
			else if (pick < 15)
				len = $urandom_range(1, 8);
			else
				len = $urandom_range(9, 40);
			amp = $urandom_range(0, 11);
			for (int i = 0; i < len && pairs_sent < TOTAL_PAIRS; i++) begin
				// Now and then close a block early, except in the over-long run.
				push_pair(draw_sample(amp), draw_sample(amp),
					(i == len - 1) || ((run_no != 2) && ($urandom_range(0, 29) == 0)));
			end
			run_no++;
		end
		in_valid <= 1'b0;

		// Drain: wait for every queued level, then idle past one full block close.
		while (tracker.pending_levels.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (tracker.pending_levels.size() != 0) begin
			tracker.errors += tracker.pending_levels.size();
			$display("%0d results never arrived", tracker.pending_levels.size());
		end

		$display("run: %0d sample pairs, %0d blocks closed (%0d at the length limit)",
			tracker.pairs_seen, tracker.blocks_closed, tracker.forced_closes);
		$display("run: %0d result mismatches, %0d errors", tracker.mismatches, tracker.errors);
		if (tracker.errors == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule

### sim.f
rtl/core/srlm_pkg.sv
rtl/core/srlm_ctrl.sv
rtl/core/srlm_dp.sv
rtl/core/stereo_rms_level_meter.sv
dv/testbench.sv
